>>> sv/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg : shared types and constants of the polygon convexity test
// Item, result and job formats, turn direction codes.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  // turn^2 shifted by 64 and tol^2*|ab|^2*|bc|^2 both fit here
  localparam int WIDE_BITS  = 4 * DIFF_BITS + 64;
  localparam int JOBQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CCW  = 2'd1;
  localparam logic [1:0] DIR_CW   = 2'd2;

  localparam logic [1:0] REG_STRICT = 2'd0;
  localparam logic [1:0] REG_TOL    = 2'd1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_vertex;
  } vertex_t;

  typedef struct packed {
    logic       is_convex;
    logic [1:0] turn_direction;
    logic       too_few_vertices;
  } result_t;

  typedef enum logic [1:0] {
    JOB_SCORE,
    JOB_LAST,
    JOB_FEW
  } job_kind_t;

  typedef struct packed {
    job_kind_t                    kind;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } job_t;

endpackage

>>> sv/pct_fifo.sv
// ----------------------------------------------------------------------------
// pct_fifo : small synchronous queue
// Register-based queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module pct_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] din,
  input  logic         rd,
  output logic [W-1:0] dout,
  output logic         empty,
  output logic         full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/pct_front.sv
// ----------------------------------------------------------------------------
// pct_front : vertex intake
// Tracks the ring; turns vertices into scoring and ring-end jobs for pct_back.
// ----------------------------------------------------------------------------
module pct_front import pct_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  vertex_t vertex,
  output logic    full,
  output logic    job_push,
  output job_t    job,
  input  logic    job_full
);

  typedef enum logic [1:0] {
    F_TAKE,
    F_WRAP1,
    F_WRAP2
  } fstate_t;

  fstate_t fstate;
  logic signed [COORD_BITS-1:0] first_x, first_y, second_x, second_y;
  logic signed [COORD_BITS-1:0] older_x, older_y, newer_x, newer_y;
  logic [1:0] vertex_count;
  logic       take;

  assign full = (fstate != F_TAKE) || job_full;
  assign take = push && !full;

  always_comb begin
    job_push = 1'b0;
    job      = '{kind: JOB_SCORE, ax: older_x, ay: older_y, bx: newer_x, by: newer_y,
                 cx: vertex.vertex_x, cy: vertex.vertex_y};
    unique case (fstate)
      F_TAKE: begin
        if (take) begin
          if (vertex_count == 2'd3 || vertex_count == 2'd2) begin
            job_push = 1'b1;
          end else if (vertex.last_vertex) begin
            job_push = 1'b1;
            job.kind = JOB_FEW;
          end
        end
      end
      F_WRAP1: begin
        job_push = !job_full;
        job      = '{kind: JOB_SCORE, ax: older_x, ay: older_y, bx: newer_x, by: newer_y,
                     cx: first_x, cy: first_y};
      end
      F_WRAP2: begin
        job_push = !job_full;
        job      = '{kind: JOB_LAST, ax: newer_x, ay: newer_y, bx: first_x, by: first_y,
                     cx: second_x, cy: second_y};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate       <= F_TAKE;
      vertex_count <= '0;
    end else begin
      unique case (fstate)
        F_TAKE: begin
          if (take) begin
            if (vertex_count == 2'd0) begin
              first_x <= vertex.vertex_x;
              first_y <= vertex.vertex_y;
            end
            if (vertex_count == 2'd1) begin
              second_x <= vertex.vertex_x;
              second_y <= vertex.vertex_y;
            end
            older_x <= newer_x;
            older_y <= newer_y;
            newer_x <= vertex.vertex_x;
            newer_y <= vertex.vertex_y;
            if (vertex.last_vertex) begin
              if (vertex_count[1]) begin
                fstate <= F_WRAP1;
              end else begin
                vertex_count <= '0;
              end
            end else if (vertex_count != 2'd3) begin
              vertex_count <= vertex_count + 1'b1;
            end
          end
        end
        F_WRAP1: begin
          if (!job_full) begin
            fstate <= F_WRAP2;
          end
        end
        F_WRAP2: begin
          if (!job_full) begin
            fstate       <= F_TAKE;
            vertex_count <= '0;
          end
        end
        default: fstate <= F_TAKE;
      endcase
    end
  end

endmodule

>>> sv/pct_back.sv
// ----------------------------------------------------------------------------
// pct_back : turn scoring engine
// Exact cross product, tolerance test by shift-add, sign tracking per ring.
// ----------------------------------------------------------------------------
module pct_back import pct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        strict_mode,
  input  logic [31:0] collinear_tolerance,
  input  job_t        job_in,
  input  logic        job_empty,
  output logic        job_pop,
  input  logic        res_full,
  output logic        res_push,
  output result_t     res
);

  typedef enum logic [3:0] {
    B_IDLE, B_DIFF, B_MP, B_MQ, B_TURN, B_M1, B_M2, B_M3, B_M4,
    B_ST2, B_STOL, B_SR1, B_SR2, B_FIN
  } bstate_t;

  bstate_t bstate;
  job_t    job;
  logic signed [DIFF_BITS-1:0] abx, aby, bcx, bcy;
  logic signed [DIFF_BITS-1:0] ma, mb;
  logic signed [PROD_BITS-1:0] prod, p, q;
  logic signed [PROD_BITS:0]   turn;
  logic [PROD_BITS-1:0] tmag, sq, l1, l2;
  logic                 neg;
  logic [WIDE_BITS-1:0] acc, mcand, mplier, lhs;
  logic [1:0]           turn_sign;
  logic                 sign_broken;
  logic [1:0]           sdir;

  assign prod    = ma * mb;
  assign turn    = (PROD_BITS+1)'(p) - (PROD_BITS+1)'(q);
  assign job_pop = (bstate == B_IDLE) && !job_empty && !res_full;
  assign sdir    = neg ? DIR_CW : DIR_CCW;

  always_comb begin
    ma = abx;
    mb = bcy;
    case (bstate)
      B_MQ: begin ma = aby; mb = bcx; end
      B_M1: begin ma = abx; mb = abx; end
      B_M2: begin ma = aby; mb = aby; end
      B_M3: begin ma = bcx; mb = bcx; end
      B_M4: begin ma = bcy; mb = bcy; end
      default: ;
    endcase
  end

  assign res_push = (bstate == B_FIN) && (job.kind != JOB_SCORE);
  always_comb begin
    if (job.kind == JOB_FEW) begin
      res = '{is_convex: 1'b0, turn_direction: DIR_NONE, too_few_vertices: 1'b1};
    end else begin
      res = '{is_convex: !sign_broken && (turn_sign != DIR_NONE),
              turn_direction: turn_sign, too_few_vertices: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate      <= B_IDLE;
      turn_sign   <= DIR_NONE;
      sign_broken <= 1'b0;
    end else begin
      unique case (bstate)
        B_IDLE: begin
          if (job_pop) begin
            job    <= job_in;
            bstate <= (job_in.kind == JOB_FEW) ? B_FIN : B_DIFF;
          end
        end
        B_DIFF: begin
          abx    <= DIFF_BITS'(job.bx) - DIFF_BITS'(job.ax);
          aby    <= DIFF_BITS'(job.by) - DIFF_BITS'(job.ay);
          bcx    <= DIFF_BITS'(job.cx) - DIFF_BITS'(job.bx);
          bcy    <= DIFF_BITS'(job.cy) - DIFF_BITS'(job.by);
          bstate <= B_MP;
        end
        B_MP: begin
          p      <= prod;
          bstate <= B_MQ;
        end
        B_MQ: begin
          q      <= prod;
          bstate <= B_TURN;
        end
        B_TURN: begin
          neg  <= turn[PROD_BITS];
          tmag <= turn[PROD_BITS] ? PROD_BITS'(-turn) : PROD_BITS'(turn);
          if (turn == '0) begin
            if (strict_mode) begin
              sign_broken <= 1'b1;
            end
            bstate <= B_FIN;
          end else if (strict_mode) begin
            if (turn_sign == DIR_NONE) begin
              turn_sign <= turn[PROD_BITS] ? DIR_CW : DIR_CCW;
            end else if (turn_sign != (turn[PROD_BITS] ? DIR_CW : DIR_CCW)) begin
              sign_broken <= 1'b1;
            end
            bstate <= B_FIN;
          end else begin
            bstate <= B_M1;
          end
        end
        B_M1: begin
          sq     <= $unsigned(prod);
          bstate <= B_M2;
        end
        B_M2: begin
          l1     <= sq + $unsigned(prod);
          bstate <= B_M3;
        end
        B_M3: begin
          sq     <= $unsigned(prod);
          bstate <= B_M4;
        end
        B_M4: begin
          l2     <= sq + $unsigned(prod);
          acc    <= '0;
          mcand  <= WIDE_BITS'(tmag);
          mplier <= WIDE_BITS'(tmag);
          bstate <= B_ST2;
        end
        B_ST2, B_STOL, B_SR1, B_SR2: begin
          if (mplier != '0) begin
            if (mplier[0]) begin
              acc <= acc + mcand;
            end
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end else begin
            acc <= '0;
            case (bstate)
              B_ST2: begin
                lhs    <= acc << 64;
                mcand  <= WIDE_BITS'(collinear_tolerance);
                mplier <= WIDE_BITS'(collinear_tolerance);
                bstate <= B_STOL;
              end
              B_STOL: begin
                mcand  <= acc;
                mplier <= WIDE_BITS'(l1);
                bstate <= B_SR1;
              end
              B_SR1: begin
                mcand  <= acc;
                mplier <= WIDE_BITS'(l2);
                bstate <= B_SR2;
              end
              default: begin
                // counts only when clearly off the line
                if (lhs > acc) begin
                  if (turn_sign == DIR_NONE) begin
                    turn_sign <= sdir;
                  end else if (turn_sign != sdir) begin
                    sign_broken <= 1'b1;
                  end
                end
                bstate <= B_FIN;
              end
            endcase
          end
        end
        B_FIN: begin
          if (job.kind != JOB_SCORE) begin
            turn_sign   <= DIR_NONE;
            sign_broken <= 1'b0;
          end
          bstate <= B_IDLE;
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule

>>> sv/polygon_convexity_test.sv
// Result: with the scorer idle a ring result follows its last vertex after
//   three scoring passes; a short ring's result needs no scoring pass.
// Throughput: one vertex per scoring pass plus two passes to close each ring;
//   tolerant passes use a serial shift-add multiplier that steps through
//   the bits of |turn|, tol, |ab|^2 and |bc|^2 in turn.
// Reset: synchronous, active high; clears ring, queues and registers.
// ----------------------------------------------------------------------------
// polygon_convexity_test : streaming polygon convexity check
// Vertices enter one per transaction; one result per ring, on its last vertex.
// ----------------------------------------------------------------------------
module polygon_convexity_test import pct_pkg::*; #(
  parameter int JOB_DEPTH = JOBQ_DEPTH,
  parameter int RES_DEPTH = RESQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // vertex side
  input  logic        push,
  input  vertex_t     vertex,
  output logic        full,
  // result side
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  // register writes
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data
);

  logic        strict_mode;
  logic [31:0] collinear_tolerance;

  // job queue between intake and scorer
  logic    fj_push, jq_full, jq_empty, jq_pop;
  job_t    fj, jq_out;
  // result queue
  logic    rs_push, rq_full;
  result_t rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode         <= 1'b0;
      collinear_tolerance <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_STRICT: strict_mode         <= wr_data[0];
        REG_TOL:    collinear_tolerance <= wr_data;
        default: ;
      endcase
    end
  end

  pct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .vertex   (vertex),
    .full     (full),
    .job_push (fj_push),
    .job      (fj),
    .job_full (jq_full)
  );

  pct_fifo #(.W($bits(job_t)), .DEPTH(JOB_DEPTH)) u_jobq (
    .clk   (clk),
    .rst   (rst),
    .wr    (fj_push),
    .din   (fj),
    .rd    (jq_pop),
    .dout  (jq_out),
    .empty (jq_empty),
    .full  (jq_full)
  );

  pct_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .strict_mode         (strict_mode),
    .collinear_tolerance (collinear_tolerance),
    .job_in              (jq_out),
    .job_empty           (jq_empty),
    .job_pop             (jq_pop),
    .res_full            (rq_full),
    .res_push            (rs_push),
    .res                 (rs)
  );

  pct_fifo #(.W($bits(result_t)), .DEPTH(RES_DEPTH)) u_resq (
    .clk   (clk),
    .rst   (rst),
    .wr    (rs_push),
    .din   (rs),
    .rd    (pop),
    .dout  (result),
    .empty (empty),
    .full  (rq_full)
  );

endmodule

>>> sv/pct_checker.sv
// ----------------------------------------------------------------------------
// pct_checker : port-level checks
// Consistency of result transactions and reset behaviour.
// ----------------------------------------------------------------------------
module pct_checker import pct_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input result_t     result
);

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_convex_dir: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.is_convex) |-> (result.turn_direction != DIR_NONE))
    else $error("convex result without a direction");

  a_few_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.too_few_vertices) |->
      (!result.is_convex && result.turn_direction == DIR_NONE))
    else $error("short ring reported a turn");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.turn_direction == DIR_NONE || result.turn_direction == DIR_CCW ||
                result.turn_direction == DIR_CW))
    else $error("bad direction code");

endmodule

bind polygon_convexity_test pct_checker u_chk (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for polygon_convexity_test
// Streams vertex rings (convex, concave, degenerate, random) under several
// mode and tolerance settings and checks every ring result against a
// bit-exact behavioural predictor of the turn-sign test.
// ----------------------------------------------------------------------------
module tb;
  import pct_pkg::*;

  localparam int  LIMIT_CYCLES = 4000000;
  localparam int  SETTLE       = 1000;   // extra idle wait after the last expected result is checked
  localparam real TWO_PI       = 6.283185307179586;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  vertex_t     vertex_in = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_STRICT;
  logic [31:0] wr_data = '0;

  polygon_convexity_test dut (
    .clk(clk), .rst(rst),
    .push(push), .vertex(vertex_in), .full(full),
    .empty(empty), .pop(pop), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and scoreboard storage
  vertex_t pending_vertices[$];
  result_t expected_rings[$];
  int      send_idle = 0;   // percent of cycles the sender holds off
  int      recv_idle = 0;   // percent of cycles the receiver holds off
  int      fails = 0;
  int      cycles = 0;
  int      vertices_sent = 0;
  int      rings_checked = 0;
  int      convex_seen = 0;
  int      few_seen = 0;
  int      unjudged_seen = 0;

  // predictor copy of the registers and ring state
  bit          mdl_strict = 1'b0;
  logic [31:0] mdl_tol = '0;
  longint      fx, fy, sx, sy, ox, oy, nx, ny;
  int          ring_count = 0;
  logic [1:0]  ring_sign = DIR_NONE;
  bit          ring_broken = 1'b0;

  // Judges one triple a, b, c by the exact turn (b - a) x (c - b).
  // Coordinates are 24 bit so the turn fits a longint with plenty spare;
  // the tolerance comparison needs ~170 bits, done at 256.
  function automatic void judge_turn(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
    longint      abx, aby, bcx, bcy, turn, len_ab, len_bc;
    logic [63:0]  mag;
    logic [255:0] lhs, rhs;
    logic [1:0]   s;
    abx = bx - ax;
    aby = by - ay;
    bcx = cx - bx;
    bcy = cy - by;
    turn = abx * bcy - aby * bcx;
    if (turn == 0) begin
      if (mdl_strict) ring_broken = 1'b1;
      return;
    end
    if (!mdl_strict) begin
      len_ab = abx * abx + aby * aby;
      len_bc = bcx * bcx + bcy * bcy;
      if (len_ab == 0 || len_bc == 0) return;
      mag = (turn < 0) ? -turn : turn;
      lhs = (256'(mag) * 256'(mag)) << 64;
      rhs = 256'(mdl_tol) * 256'(mdl_tol) * 256'(len_ab) * 256'(len_bc);
      if (lhs <= rhs) return;   // near-collinear, not counted
    end
    s = (turn < 0) ? DIR_CW : DIR_CCW;
    if (ring_sign == DIR_NONE) ring_sign = s;
    else if (ring_sign != s) ring_broken = 1'b1;
  endfunction

  // Advances the ring state by one accepted vertex; queues a result on the last.
  function automatic void predict_vertex(vertex_t v);
    longint  vx, vy;
    int      prior;
    result_t r;
    vx = v.vertex_x;
    vy = v.vertex_y;
    prior = ring_count;
    if (prior == 0) begin
      fx = vx; fy = vy;
    end else if (prior == 1) begin
      sx = vx; sy = vy;
    end else begin
      judge_turn(ox, oy, nx, ny, vx, vy);
    end
    ox = nx; oy = ny;
    nx = vx; ny = vy;
    if (ring_count < 3) ring_count++;
    if (!v.last_vertex) return;
    if (prior < 2) begin
      r.is_convex = 1'b0;
      r.turn_direction = DIR_NONE;
      r.too_few_vertices = 1'b1;
    end else begin
      // the two wrap-around triples close the ring
      judge_turn(ox, oy, nx, ny, fx, fy);
      judge_turn(nx, ny, fx, fy, sx, sy);
      r.is_convex = !ring_broken && ring_sign != DIR_NONE;
      r.turn_direction = ring_sign;
      r.too_few_vertices = 1'b0;
    end
    expected_rings = {expected_rings, r};
    fx = 0; fy = 0; sx = 0; sy = 0; ox = 0; oy = 0; nx = 0; ny = 0;
    ring_count = 0;
    ring_sign = DIR_NONE;
    ring_broken = 1'b0;
  endfunction

  // Driver: keeps push high across back-to-back transactions, prediction and
  // register tracking happen on the same edge the DUT sees them.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_STRICT) mdl_strict = wr_data[0];
        else if (wr_index == REG_TOL) mdl_tol = wr_data;
      end
      if (push && !full) begin
        predict_vertex(vertex_in);
        vertices_sent++;
      end
      if (!push || !full) begin
        if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle) begin
          vertex_in <= pending_vertices.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: one compare per popped transaction against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_rings.size() == 0) begin
          $error("unexpected result %p", result);
          fails++;
        end else begin
          want = expected_rings.pop_front();
          rings_checked++;
          if (want.is_convex) convex_seen++;
          if (want.too_few_vertices) few_seen++;
          if (!want.too_few_vertices && want.turn_direction == DIR_NONE) unjudged_seen++;
          if (result.is_convex !== want.is_convex) begin
            $error("is_convex: expected %0d, got %0d", want.is_convex, result.is_convex);
            fails++;
          end
          if (result.turn_direction !== want.turn_direction) begin
            $error("turn_direction: expected %0d, got %0d",
                   want.turn_direction, result.turn_direction);
            fails++;
          end
          if (result.too_few_vertices !== want.too_few_vertices) begin
            $error("too_few_vertices: expected %0d, got %0d",
                   want.too_few_vertices, result.too_few_vertices);
            fails++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic void add_vertex(longint x, longint y, bit last);
    vertex_t v;
    v.vertex_x = x[COORD_BITS-1:0];
    v.vertex_y = y[COORD_BITS-1:0];
    v.last_vertex = last;
    pending_vertices = {pending_vertices, v};
  endfunction

  // Points on a circle at increasing angles; small radii make rounding
  // produce collinear and slightly concave cases for free.
  function automatic void add_circle_ring(int n, longint r, bit clockwise, bit degrade);
    longint cx, cy, px, py;
    real    a;
    int     dup;
    cx = longint'($urandom_range(8388606)) - 4194303;
    cy = longint'($urandom_range(8388606)) - 4194303;
    dup = degrade ? $urandom_range(n - 1) : -1;
    for (int k = 0; k < n; k++) begin
      a = TWO_PI * (k + 0.8 * $urandom_range(1000) / 1000.0) / n;
      if (clockwise) a = -a;
      px = cx + $rtoi(r * $cos(a));
      py = cy + $rtoi(r * $sin(a));
      if (k == dup) begin
        // repeated vertex, or the same vertex shifted by one in x
        add_vertex(px, py, 1'b0);
        if ($urandom_range(1)) px = px + 1;
      end
      add_vertex(px, py, k == n - 1);
    end
  endfunction

  function automatic void add_random_ring();
    int     n, span;
    longint x, y;
    n = $urandom_range(1, 6);
    span = $urandom_range(2);
    for (int k = 0; k < n; k++) begin
      if (span == 0) begin
        x = $signed($urandom_range(32'h00ffffff)) - 8388608;
        y = $signed($urandom_range(32'h00ffffff)) - 8388608;
      end else begin
        x = longint'($urandom_range(8)) - 4;
        y = longint'($urandom_range(8)) - 4;
      end
      add_vertex(x, y, k == n - 1);
    end
  endfunction

  function automatic void add_random_rings(int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 65)
        add_circle_ring($urandom_range(3, 8),
                        $urandom_range(1) ? $urandom_range(4194000) : $urandom_range(3, 40),
                        $urandom_range(1), $urandom_range(3) == 0);
      else
        add_random_ring();
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending_vertices.size() > 0 || push || expected_rings.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_directed();
    add_vertex(5, 5, 1'b1);                                       // lone vertex
    add_vertex(-8388608, 8388607, 1'b0); add_vertex(0, 0, 1'b1);  // two vertices
    add_vertex(0, 0, 1'b0); add_vertex(10, 0, 1'b0); add_vertex(0, 10, 1'b1);  // ccw
    add_vertex(0, 0, 1'b0); add_vertex(0, 10, 1'b0); add_vertex(10, 0, 1'b1);  // cw
    // full-range square
    add_vertex(-8388608, -8388608, 1'b0); add_vertex(8388607, -8388608, 1'b0);
    add_vertex(8388607, 8388607, 1'b0);   add_vertex(-8388608, 8388607, 1'b1);
    // all collinear: nothing counts in tolerant mode
    add_vertex(0, 0, 1'b0); add_vertex(1, 1, 1'b0); add_vertex(2, 2, 1'b1);
    // zero-length edge inside a triangle
    add_vertex(0, 0, 1'b0); add_vertex(0, 0, 1'b0); add_vertex(7, 0, 1'b0);
    add_vertex(0, 7, 1'b1);
    // concave arrow
    add_vertex(0, 0, 1'b0); add_vertex(8, 4, 1'b0); add_vertex(0, 8, 1'b0);
    add_vertex(3, 4, 1'b1);
  endtask

  logic [31:0] tol_list[8] = '{32'd0, 32'd0, 32'd1, 32'h0010_0000,
                               32'hffff_ffff, 32'hffff_ffff, 32'h1000_0000, 32'h1000_0000};
  bit          strict_list[8] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

  initial begin
    fx = 0; fy = 0; sx = 0; sy = 0; ox = 0; oy = 0; nx = 0; ny = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle = 37; recv_idle = 47;
      end else if (ph < 6) begin
        send_idle = 47; recv_idle = 37;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      write_reg(REG_STRICT, {31'd0, strict_list[ph]});
      write_reg(REG_TOL, tol_list[ph]);
      if (ph == 0 || ph == 1) add_directed();
      add_random_rings(32);
      drain();
    end
    $display("%0d vertices in %0d rings over 8 mode/tolerance settings",
             vertices_sent, rings_checked);
    $display("%0d convex, %0d too few vertices, %0d with no counted turn",
             convex_seen, few_seen, unjudged_seen);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
sv/pct_pkg.sv
sv/pct_fifo.sv
sv/pct_front.sv
sv/pct_back.sv
sv/polygon_convexity_test.sv
sv/pct_checker.sv
tb/sv/tb.sv
